/* rtl/mpm_pkg.sv */
// mpm_pkg: shared types and codes of the multi-pattern matcher
// depends on nothing; used by multi_pattern_matcher_core, mpm_node_mem and mpm_pat_mem
package mpm_pkg;

  // operation codes of an input transaction
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_TEXT    = 2'd2;

  // input transaction
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] symbol;
    logic       end_of_pattern;
    logic       start_of_text;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [5:0]  pattern_id;
    logic [31:0] match_position;
    logic        last_match;
    logic        table_full;
  } out_item_t;

  // per-field write enables of the node store
  typedef struct packed {
    logic fail;
    logic outl;
    logic depth;
    logic head;
  } node_we_t;

  // per-field write enables of the pattern store
  typedef struct packed {
    logic link;
    logic len;
  } pat_we_t;

endpackage

/* rtl/multi_pattern_matcher_core.sv */
// multi_pattern_matcher_core: aho-corasick engine around goto, node, pattern and queue memories
// depends on mpm_pkg, mpm_child_mem, mpm_node_mem, mpm_pat_mem
//
//   channel  ports                      handshake
//   input    in_data                    taken when start and not busy
//   result   out_data                   one cycle, marked by out_valid
//
// steps: a pattern symbol is a goto lookup, skipped while a pattern is dropped, and a walk
//   over the node's pattern list when it closes a pattern at an existing node; a text symbol
//   is a goto walk with failure hops, then the dictionary chain and each pattern reported,
//   after a link build over every trie node, child and failure hop after any change;
//   clear sweeps the goto table rows of the nodes in use
// reset: a clearing pass over the whole goto table
// every step is one read of a registered memory; busy covers all
// results appear one per cycle at most; the receiver cannot stall
module multi_pattern_matcher_core #(
  parameter int MAX_NODES    = 256,
  parameter int MAX_PATTERNS = 64,
  parameter int SYMBOL_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mpm_pkg::in_item_t  in_data,
  output logic               out_valid,
  output mpm_pkg::out_item_t out_data
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = NW + 1;
  localparam int SB  = SYMBOL_BITS;
  localparam int PW  = $clog2(MAX_PATTERNS + 1);
  localparam int PIW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam logic [PW-1:0] NO_PAT   = PW'(MAX_PATTERNS);
  localparam logic [CW-1:0] NODE_MAX = CW'(MAX_NODES);
  localparam logic [PW-1:0] PAT_MAX  = PW'(MAX_PATTERNS);
  localparam logic [SB-1:0] SYM_LAST = {SB{1'b1}};

  typedef enum logic [18:0] {
    ST_IDLE    = 19'h00001,
    ST_CLR     = 19'h00002,
    ST_P_CHK   = 19'h00004,
    ST_P_EOP   = 19'h00008,
    ST_P_WALK  = 19'h00010,
    ST_B0      = 19'h00020,
    ST_BQ      = 19'h00040,
    ST_BQ_GET  = 19'h00080,
    ST_BU      = 19'h00100,
    ST_BS      = 19'h00200,
    ST_BF_CHK  = 19'h00400,
    ST_BF_NODE = 19'h00800,
    ST_BG      = 19'h01000,
    ST_BG_N    = 19'h02000,
    ST_M_CHK   = 19'h04000,
    ST_M_FAIL  = 19'h08000,
    ST_E_NODE  = 19'h10000,
    ST_E_PAT   = 19'h20000,
    ST_FIN     = 19'h40000
  } state_t;

  // control registers
  state_t           state_r, state_nxt;
  logic [NW+SB-1:0] sweep_r, sweep_nxt;
  logic [CW-1:0]    limit_r, limit_nxt;
  logic [CW-1:0]    node_count_r, node_count_nxt;
  logic [PW-1:0]    pat_count_r, pat_count_nxt;
  logic [NW-1:0]    cursor_r, cursor_nxt;
  logic             dropping_r, dropping_nxt;
  logic [NW-1:0]    match_r, match_nxt;
  logic [31:0]      offset_r, offset_nxt;
  logic             links_r, links_nxt;
  logic             full_r, full_nxt;
  logic [CW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    tail_r, tail_nxt;
  logic [SB-1:0]    scnt_r, scnt_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload registers
  logic [SB-1:0]      sym_r, sym_nxt;
  logic               eop_r, eop_nxt;
  logic [NW-1:0]      u_r, u_nxt;
  logic [NW-1:0]      fu_r, fu_nxt;
  logic [NW-1:0]      c_r, c_nxt;
  logic [NW-1:0]      f_r, f_nxt;
  logic [NW-1:0]      g_r, g_nxt;
  logic [NW-1:0]      v_r, v_nxt;
  logic [NW-1:0]      ol_r, ol_nxt;
  logic [PW-1:0]      p_r, p_nxt;
  logic [PW-1:0]      id_r, id_nxt;
  logic [5:0]         pend_id_r, pend_id_nxt;
  logic [31:0]        pend_pos_r, pend_pos_nxt;
  mpm_pkg::out_item_t out_data_r, out_data_nxt;

  // memory ports
  logic [NW-1:0]     c_rn, c_wn, c_wd, c_q;
  logic [SB-1:0]     c_rs, c_ws;
  logic              c_we;
  logic [NW-1:0]     n_ra, n_wa, n_wfail, n_woutl, n_wdepth;
  logic [PW-1:0]     n_whead;
  logic [NW-1:0]     n_fail_q, n_outl_q, n_depth_q;
  logic [PW-1:0]     n_head_q;
  mpm_pkg::node_we_t n_we;
  logic [PIW-1:0]    p_ra, p_wa;
  logic [PW-1:0]     p_wlink, p_link_q;
  logic [NW-1:0]     p_wlen, p_len_q;
  mpm_pkg::pat_we_t  p_we;
  logic              q_we;
  logic [NW-1:0]     q_wa, q_wd, q_ra, q_q;
  logic [NW-1:0]     mv;

  logic [NW-1:0] queue_mem [MAX_NODES];

  mpm_child_mem #(.NW(NW), .SB(SB)) u_child (
    .clk(clk), .rd_node(c_rn), .rd_sym(c_rs), .rd_q(c_q),
    .we(c_we), .wr_node(c_wn), .wr_sym(c_ws), .wr_data(c_wd)
  );

  mpm_node_mem #(.MAX_NODES(MAX_NODES), .NW(NW), .PW(PW)) u_node (
    .clk(clk), .rd_addr(n_ra), .rd_fail(n_fail_q), .rd_outl(n_outl_q),
    .rd_depth(n_depth_q), .rd_head(n_head_q), .we(n_we), .wr_addr(n_wa),
    .wr_fail(n_wfail), .wr_outl(n_woutl), .wr_depth(n_wdepth), .wr_head(n_whead)
  );

  mpm_pat_mem #(.MAX_PATTERNS(MAX_PATTERNS), .NW(NW), .PW(PW), .PIW(PIW)) u_pat (
    .clk(clk), .rd_addr(p_ra), .rd_link(p_link_q), .rd_len(p_len_q),
    .we(p_we), .wr_addr(p_wa), .wr_link(p_wlink), .wr_len(p_wlen)
  );

  // breadth-first queue of the link build
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_wa] <= q_wd;
    end
    q_q <= queue_mem[q_ra];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    limit_nxt      = limit_r;
    node_count_nxt = node_count_r;
    pat_count_nxt  = pat_count_r;
    cursor_nxt     = cursor_r;
    dropping_nxt   = dropping_r;
    match_nxt      = match_r;
    offset_nxt     = offset_r;
    links_nxt      = links_r;
    full_nxt       = full_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    scnt_nxt       = scnt_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    sym_nxt        = sym_r;
    eop_nxt        = eop_r;
    u_nxt          = u_r;
    fu_nxt         = fu_r;
    c_nxt          = c_r;
    f_nxt          = f_r;
    g_nxt          = g_r;
    v_nxt          = v_r;
    ol_nxt         = ol_r;
    p_nxt          = p_r;
    id_nxt         = id_r;
    pend_id_nxt    = pend_id_r;
    pend_pos_nxt   = pend_pos_r;
    out_data_nxt   = out_data_r;
    c_rn = '0; c_rs = '0; c_we = 1'b0; c_wn = '0; c_ws = '0; c_wd = '0;
    n_ra = '0; n_we = '0; n_wa = '0; n_wfail = '0; n_woutl = '0;
    n_wdepth = '0; n_whead = NO_PAT;
    p_ra = '0; p_we = '0; p_wa = '0; p_wlink = NO_PAT; p_wlen = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    mv = in_data.start_of_text ? '0 : match_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          sym_nxt = in_data.symbol[SB-1:0];
          eop_nxt = in_data.end_of_pattern;
          case (in_data.opcode)
            mpm_pkg::OP_CLEAR: begin
              node_count_nxt = CW'(1);
              pat_count_nxt  = '0;
              cursor_nxt     = '0;
              match_nxt      = '0;
              links_nxt      = 1'b0;
              full_nxt       = 1'b0;
              dropping_nxt   = 1'b0;
              limit_nxt      = node_count_r;
              sweep_nxt      = '0;
              state_nxt      = ST_CLR;
            end
            mpm_pkg::OP_PATTERN: begin
              links_nxt = 1'b0;
              if (dropping_r) begin
                if (in_data.end_of_pattern) begin
                  dropping_nxt = 1'b0;
                  cursor_nxt   = '0;
                end
              end else begin
                c_rn      = cursor_r;
                c_rs      = in_data.symbol[SB-1:0];
                n_ra      = cursor_r;
                state_nxt = ST_P_CHK;
              end
            end
            mpm_pkg::OP_TEXT: begin
              if (in_data.start_of_text) begin
                match_nxt  = '0;
                offset_nxt = '0;
              end
              if (!links_r) begin
                scnt_nxt  = '0;
                head_nxt  = '0;
                tail_nxt  = '0;
                state_nxt = ST_B0;
              end else begin
                v_nxt     = mv;
                c_rn      = mv;
                c_rs      = in_data.symbol[SB-1:0];
                state_nxt = ST_M_CHK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // clearing pass over the goto table, root entry rewritten alongside
      ST_CLR: begin
        c_we     = 1'b1;
        c_wn     = sweep_r[NW+SB-1:SB];
        c_ws     = sweep_r[SB-1:0];
        n_we     = '1;
        n_whead  = NO_PAT;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r[SB-1:0] == SYM_LAST &&
            {1'b0, sweep_r[NW+SB-1:SB]} == limit_r - CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // goto edge lookup while inserting
      ST_P_CHK: begin
        state_nxt = ST_IDLE;
        if (c_q == '0) begin
          if (node_count_r < NODE_MAX) begin
            c_we     = 1'b1;
            c_wn     = cursor_r;
            c_ws     = sym_r;
            c_wd     = node_count_r[NW-1:0];
            n_we     = '1;
            n_wa     = node_count_r[NW-1:0];
            n_wdepth = n_depth_q + NW'(1);
            node_count_nxt = node_count_r + 1'b1;
            if (eop_r) begin
              cursor_nxt = '0;
              if (pat_count_r < PAT_MAX) begin
                n_whead       = pat_count_r;
                p_we          = '1;
                p_wa          = pat_count_r[PIW-1:0];
                p_wlen        = n_depth_q + NW'(1);
                pat_count_nxt = pat_count_r + 1'b1;
              end else begin
                full_nxt = 1'b1;
              end
            end else begin
              cursor_nxt = node_count_r[NW-1:0];
            end
          end else begin
            full_nxt = 1'b1;
            if (eop_r) begin
              dropping_nxt = 1'b0;
              cursor_nxt   = '0;
            end else begin
              dropping_nxt = 1'b1;
            end
          end
        end else if (eop_r) begin
          n_ra       = c_q;
          cursor_nxt = c_q;
          state_nxt  = ST_P_EOP;
        end else begin
          cursor_nxt = c_q;
        end
      end

      // pattern ends at an existing node
      ST_P_EOP: begin
        cursor_nxt = '0;
        state_nxt  = ST_IDLE;
        if (pat_count_r >= PAT_MAX) begin
          full_nxt = 1'b1;
        end else begin
          id_nxt        = pat_count_r;
          p_we          = '1;
          p_wa          = pat_count_r[PIW-1:0];
          p_wlen        = n_depth_q;
          pat_count_nxt = pat_count_r + 1'b1;
          if (n_head_q == NO_PAT) begin
            n_we.head = 1'b1;
            n_wa      = cursor_r;
            n_whead   = pat_count_r;
          end else begin
            p_nxt     = n_head_q;
            p_ra      = n_head_q[PIW-1:0];
            state_nxt = ST_P_WALK;
          end
        end
      end

      // walk to the tail of the node's pattern list
      ST_P_WALK: begin
        if (p_link_q == NO_PAT) begin
          p_we.link = 1'b1;
          p_wa      = p_r[PIW-1:0];
          p_wlink   = id_r;
          state_nxt = ST_IDLE;
        end else begin
          p_nxt = p_link_q;
          p_ra  = p_link_q[PIW-1:0];
        end
      end

      // children of the root enter the queue
      ST_B0: begin
        if (c_q != '0 && tail_r < NODE_MAX) begin
          n_we.fail = 1'b1;
          n_we.outl = 1'b1;
          n_wa      = c_q;
          q_we      = 1'b1;
          q_wa      = tail_r[NW-1:0];
          q_wd      = c_q;
          tail_nxt  = tail_r + 1'b1;
        end
        if (scnt_r == SYM_LAST) begin
          state_nxt = ST_BQ;
        end else begin
          scnt_nxt = scnt_r + 1'b1;
          c_rs     = scnt_r + 1'b1;
        end
      end

      // next node from the queue, or start matching
      ST_BQ: begin
        if (head_r < tail_r) begin
          q_ra      = head_r[NW-1:0];
          state_nxt = ST_BQ_GET;
        end else begin
          links_nxt = 1'b1;
          v_nxt     = match_r;
          c_rn      = match_r;
          c_rs      = sym_r;
          state_nxt = ST_M_CHK;
        end
      end

      ST_BQ_GET: begin
        u_nxt     = q_q;
        head_nxt  = head_r + 1'b1;
        n_ra      = q_q;
        state_nxt = ST_BU;
      end

      ST_BU: begin
        fu_nxt    = n_fail_q;
        scnt_nxt  = '0;
        c_rn      = u_r;
        state_nxt = ST_BS;
      end

      // one child of the dequeued node
      ST_BS: begin
        if (c_q == '0 || tail_r >= NODE_MAX) begin
          if (scnt_r == SYM_LAST) begin
            state_nxt = ST_BQ;
          end else begin
            scnt_nxt = scnt_r + 1'b1;
            c_rn     = u_r;
            c_rs     = scnt_r + 1'b1;
          end
        end else begin
          c_nxt = c_q;
          c_rs  = scnt_r;
          if (fu_r == '0) begin
            state_nxt = ST_BG;
          end else begin
            f_nxt     = fu_r;
            c_rn      = fu_r;
            state_nxt = ST_BF_CHK;
          end
        end
      end

      // failure walk of the link build
      ST_BF_CHK: begin
        if (c_q != '0) begin
          g_nxt     = c_q;
          n_ra      = c_q;
          state_nxt = ST_BG_N;
        end else begin
          n_ra      = f_r;
          state_nxt = ST_BF_NODE;
        end
      end

      ST_BF_NODE: begin
        c_rs = scnt_r;
        if (n_fail_q == '0) begin
          state_nxt = ST_BG;
        end else begin
          f_nxt     = n_fail_q;
          c_rn      = n_fail_q;
          state_nxt = ST_BF_CHK;
        end
      end

      ST_BG: begin
        g_nxt     = c_q;
        n_ra      = c_q;
        state_nxt = ST_BG_N;
      end

      // write links of the child and queue it
      ST_BG_N: begin
        n_we.fail = 1'b1;
        n_we.outl = 1'b1;
        n_wa      = c_r;
        n_wfail   = g_r;
        n_woutl   = (n_head_q != NO_PAT) ? g_r : n_outl_q;
        q_we      = 1'b1;
        q_wa      = tail_r[NW-1:0];
        q_wd      = c_r;
        tail_nxt  = tail_r + 1'b1;
        if (scnt_r == SYM_LAST) begin
          state_nxt = ST_BQ;
        end else begin
          scnt_nxt  = scnt_r + 1'b1;
          c_rn      = u_r;
          c_rs      = scnt_r + 1'b1;
          state_nxt = ST_BS;
        end
      end

      // goto or failure step of the text walk
      ST_M_CHK: begin
        if (v_r == '0 || c_q != '0) begin
          match_nxt = c_q;
          if (c_q == '0) begin
            state_nxt = ST_FIN;
          end else begin
            n_ra      = c_q;
            state_nxt = ST_E_NODE;
          end
        end else begin
          n_ra      = v_r;
          state_nxt = ST_M_FAIL;
        end
      end

      ST_M_FAIL: begin
        v_nxt     = n_fail_q;
        c_rn      = n_fail_q;
        c_rs      = sym_r;
        state_nxt = ST_M_CHK;
      end

      // node on the dictionary chain
      ST_E_NODE: begin
        ol_nxt = n_outl_q;
        if (n_head_q == NO_PAT) begin
          if (n_outl_q == '0) begin
            state_nxt = ST_FIN;
          end else begin
            n_ra = n_outl_q;
          end
        end else begin
          p_nxt     = n_head_q;
          p_ra      = n_head_q[PIW-1:0];
          state_nxt = ST_E_PAT;
        end
      end

      // one pattern found, the previous one goes out
      ST_E_PAT: begin
        if (pend_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{pattern_id: pend_id_r, match_position: pend_pos_r,
                            last_match: 1'b0, table_full: full_r};
        end
        pend_nxt     = 1'b1;
        pend_id_nxt  = 6'(p_r[PIW-1:0]);
        pend_pos_nxt = offset_r - 32'(p_len_q) + 32'd1;
        if (p_link_q == NO_PAT) begin
          if (ol_r == '0) begin
            state_nxt = ST_FIN;
          end else begin
            n_ra      = ol_r;
            state_nxt = ST_E_NODE;
          end
        end else begin
          p_nxt = p_link_q;
          p_ra  = p_link_q[PIW-1:0];
        end
      end

      // last result of the symbol and position advance
      ST_FIN: begin
        offset_nxt = offset_r + 32'd1;
        if (pend_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{pattern_id: pend_id_r, match_position: pend_pos_r,
                            last_match: 1'b1, table_full: full_r};
          pend_nxt      = 1'b0;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      sweep_r      <= '0;
      limit_r      <= NODE_MAX;
      node_count_r <= CW'(1);
      pat_count_r  <= '0;
      cursor_r     <= '0;
      dropping_r   <= 1'b0;
      match_r      <= '0;
      offset_r     <= '0;
      links_r      <= 1'b0;
      full_r       <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      scnt_r       <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      limit_r      <= limit_nxt;
      node_count_r <= node_count_nxt;
      pat_count_r  <= pat_count_nxt;
      cursor_r     <= cursor_nxt;
      dropping_r   <= dropping_nxt;
      match_r      <= match_nxt;
      offset_r     <= offset_nxt;
      links_r      <= links_nxt;
      full_r       <= full_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      scnt_r       <= scnt_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    eop_r      <= eop_nxt;
    u_r        <= u_nxt;
    fu_r       <= fu_nxt;
    c_r        <= c_nxt;
    f_r        <= f_nxt;
    g_r        <= g_nxt;
    v_r        <= v_nxt;
    ol_r       <= ol_nxt;
    p_r        <= p_nxt;
    id_r       <= id_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_pos_r <= pend_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no held result survives the end of a text symbol
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_r)
    else $error("result left pending in idle");

  // results leave only from the report states
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_E_PAT || state_r == ST_FIN))
    else $error("result strobe from unexpected state");

  // node count stays within the trie
  a_node_count: assert property (@(posedge clk) disable iff (!rst_n)
    (node_count_r != '0) && (node_count_r <= NODE_MAX))
    else $error("node count out of range");

  // dequeue only from a non-empty queue
  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BQ_GET) |-> (head_r < tail_r))
    else $error("queue read beyond tail");

endmodule

/* rtl/mpm_child_mem.sv */
// mpm_child_mem: trie goto table, one entry per node and symbol
// depends on nothing; instantiated by multi_pattern_matcher_core
module mpm_child_mem #(
  parameter int NW = 8,
  parameter int SB = 8
) (
  input  logic          clk,
  input  logic [NW-1:0] rd_node,
  input  logic [SB-1:0] rd_sym,
  output logic [NW-1:0] rd_q,
  input  logic          we,
  input  logic [NW-1:0] wr_node,
  input  logic [SB-1:0] wr_sym,
  input  logic [NW-1:0] wr_data
);

  localparam int DEPTH = 1 << (NW + SB);

  logic [NW-1:0] mem [DEPTH];

  // write port, entry zero means no edge
  always_ff @(posedge clk) begin
    if (we) begin
      mem[{wr_node, wr_sym}] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_q <= mem[{rd_node, rd_sym}];
  end

endmodule

/* rtl/mpm_node_mem.sv */
// mpm_node_mem: per-node failure link, dictionary link, depth and pattern list head
// depends on mpm_pkg; instantiated by multi_pattern_matcher_core
module mpm_node_mem #(
  parameter int MAX_NODES = 256,
  parameter int NW        = 8,
  parameter int PW        = 7
) (
  input  logic              clk,
  input  logic [NW-1:0]     rd_addr,
  output logic [NW-1:0]     rd_fail,
  output logic [NW-1:0]     rd_outl,
  output logic [NW-1:0]     rd_depth,
  output logic [PW-1:0]     rd_head,
  input  mpm_pkg::node_we_t we,
  input  logic [NW-1:0]     wr_addr,
  input  logic [NW-1:0]     wr_fail,
  input  logic [NW-1:0]     wr_outl,
  input  logic [NW-1:0]     wr_depth,
  input  logic [PW-1:0]     wr_head
);

  logic [NW-1:0] fail_mem  [MAX_NODES];
  logic [NW-1:0] outl_mem  [MAX_NODES];
  logic [NW-1:0] depth_mem [MAX_NODES];
  logic [PW-1:0] head_mem  [MAX_NODES];

  // field-wise writes at a shared address
  always_ff @(posedge clk) begin
    if (we.fail)  fail_mem[wr_addr]  <= wr_fail;
    if (we.outl)  outl_mem[wr_addr]  <= wr_outl;
    if (we.depth) depth_mem[wr_addr] <= wr_depth;
    if (we.head)  head_mem[wr_addr]  <= wr_head;
  end

  // registered read of all fields
  always_ff @(posedge clk) begin
    rd_fail  <= fail_mem[rd_addr];
    rd_outl  <= outl_mem[rd_addr];
    rd_depth <= depth_mem[rd_addr];
    rd_head  <= head_mem[rd_addr];
  end

endmodule

/* rtl/mpm_pat_mem.sv */
// mpm_pat_mem: per-pattern list link and pattern length
// depends on mpm_pkg; instantiated by multi_pattern_matcher_core
module mpm_pat_mem #(
  parameter int MAX_PATTERNS = 64,
  parameter int NW           = 8,
  parameter int PW           = 7,
  parameter int PIW          = 6
) (
  input  logic             clk,
  input  logic [PIW-1:0]   rd_addr,
  output logic [PW-1:0]    rd_link,
  output logic [NW-1:0]    rd_len,
  input  mpm_pkg::pat_we_t we,
  input  logic [PIW-1:0]   wr_addr,
  input  logic [PW-1:0]    wr_link,
  input  logic [NW-1:0]    wr_len
);

  logic [PW-1:0] link_mem [MAX_PATTERNS];
  logic [NW-1:0] len_mem  [MAX_PATTERNS];

  // field-wise writes
  always_ff @(posedge clk) begin
    if (we.link) link_mem[wr_addr] <= wr_link;
    if (we.len)  len_mem[wr_addr]  <= wr_len;
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_link <= link_mem[rd_addr];
    rd_len  <= len_mem[rd_addr];
  end

endmodule

/* test/tb_top.sv */
// tb_top: self-checking regression of multi_pattern_matcher_core
// depends on mpm_pkg and the rtl of multi_pattern_matcher_core
// drives queued transactions, predicts matches in a behavioural automaton, checks each result
module tb_top;

  localparam int NODE_LIMIT = 256;
  localparam int PAT_LIMIT  = 64;
  localparam int SYM_COUNT  = 256;
  localparam int NO_PAT     = PAT_LIMIT;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    mpm_pkg::in_item_t item;
    bit                drain;
  } queued_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  mpm_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  mpm_pkg::out_item_t out_data;

  queued_cmd_t        pending_cmds[$];
  mpm_pkg::out_item_t expected_matches[$];
  int                 idle_left = 0;
  int                 errors = 0;

  // behavioural automaton state
  int unsigned goto_tbl[SYM_COUNT * NODE_LIMIT];
  int unsigned fail_of[NODE_LIMIT];
  int unsigned dict_of[NODE_LIMIT];
  int unsigned depth_of[NODE_LIMIT];
  int unsigned head_pat[NODE_LIMIT];
  int unsigned next_pat[PAT_LIMIT];
  int unsigned len_pat[PAT_LIMIT];
  int unsigned bfs_fifo[NODE_LIMIT];
  int unsigned nodes, pats, cursor, cur_node;
  bit [31:0]   offset;
  bit          links_ok, full_seen, dropping;

  multi_pattern_matcher_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // empty trie and pattern list
  function automatic void trie_clear();
    for (int i = 0; i < SYM_COUNT * NODE_LIMIT; i++) goto_tbl[i] = 0;
    nodes = 1;
    depth_of[0] = 0;
    head_pat[0] = NO_PAT;
    fail_of[0] = 0;
    dict_of[0] = 0;
    pats = 0;
    cursor = 0;
    cur_node = 0;
    links_ok = 0;
    full_seen = 0;
    dropping = 0;
  endfunction

  // breadth-first failure and dictionary links
  function automatic void links_build();
    int unsigned hd, tl, u, c, f, g;
    hd = 0;
    tl = 0;
    for (int s = 0; s < SYM_COUNT; s++) begin
      c = goto_tbl[s];
      if (c != 0 && tl < NODE_LIMIT) begin
        fail_of[c] = 0;
        dict_of[c] = 0;
        bfs_fifo[tl] = c;
        tl++;
      end
    end
    while (hd < tl) begin
      u = bfs_fifo[hd];
      hd++;
      for (int s = 0; s < SYM_COUNT; s++) begin
        c = goto_tbl[u * SYM_COUNT + s];
        if (c != 0 && tl < NODE_LIMIT) begin
          f = fail_of[u];
          while (f != 0 && goto_tbl[f * SYM_COUNT + s] == 0) f = fail_of[f];
          g = goto_tbl[f * SYM_COUNT + s];
          fail_of[c] = g;
          dict_of[c] = (head_pat[g] != NO_PAT) ? g : dict_of[g];
          bfs_fifo[tl] = c;
          tl++;
        end
      end
    end
    links_ok = 1;
  endfunction

  // extend the trie by one pattern symbol
  function automatic void pattern_extend(int unsigned s, bit eop);
    int unsigned slot, nxt, p, id;
    links_ok = 0;
    if (!dropping) begin
      slot = cursor * SYM_COUNT + s;
      nxt = goto_tbl[slot];
      if (nxt == 0) begin
        if (nodes >= NODE_LIMIT) begin
          full_seen = 1;
          dropping = 1;
        end else begin
          nxt = nodes;
          nodes++;
          goto_tbl[slot] = nxt;
          depth_of[nxt] = depth_of[cursor] + 1;
          head_pat[nxt] = NO_PAT;
          fail_of[nxt] = 0;
          dict_of[nxt] = 0;
        end
      end
      if (!dropping) cursor = nxt;
    end
    if (eop) begin
      if (!dropping) begin
        if (pats >= PAT_LIMIT) begin
          full_seen = 1;
        end else begin
          id = pats;
          pats++;
          next_pat[id] = NO_PAT;
          len_pat[id] = depth_of[cursor];
          if (head_pat[cursor] == NO_PAT) begin
            head_pat[cursor] = id;
          end else begin
            p = head_pat[cursor];
            while (next_pat[p] != NO_PAT) p = next_pat[p];
            next_pat[p] = id;
          end
        end
      end
      dropping = 0;
      cursor = 0;
    end
  endfunction

  // apply one accepted transaction, queue the matches it reports
  function automatic void advance_matcher(mpm_pkg::in_item_t it);
    int unsigned v, p, n, s;
    mpm_pkg::out_item_t r;
    n = 0;
    s = 32'(it.symbol);
    case (it.opcode)
      mpm_pkg::OP_CLEAR: trie_clear();
      mpm_pkg::OP_PATTERN: pattern_extend(s, it.end_of_pattern);
      mpm_pkg::OP_TEXT: begin
        if (it.start_of_text) begin
          cur_node = 0;
          offset = '0;
        end
        if (!links_ok) links_build();
        v = cur_node;
        while (v != 0 && goto_tbl[v * SYM_COUNT + s] == 0) v = fail_of[v];
        v = goto_tbl[v * SYM_COUNT + s];
        cur_node = v;
        while (v != 0) begin
          p = head_pat[v];
          while (p != NO_PAT && n < PAT_LIMIT) begin
            r.pattern_id = p[5:0];
            r.match_position = offset - len_pat[p] + 32'd1;
            r.last_match = 1'b0;
            r.table_full = full_seen;
            expected_matches.push_back(r);
            n++;
            p = next_pat[p];
          end
          v = dict_of[v];
        end
        if (n > 0) expected_matches[expected_matches.size() - 1].last_match = 1'b1;
        offset = offset + 32'd1;
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void queue_cmd(logic [1:0] op, logic [7:0] sym, bit eop, bit sot,
                                    bit drain = 0);
    queued_cmd_t q;
    q.item.opcode = op;
    q.item.symbol = sym;
    q.item.end_of_pattern = eop;
    q.item.start_of_text = sot;
    q.drain = drain;
    pending_cmds.push_back(q);
  endfunction

  // driver: next transaction after acceptance or idle, with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) advance_matcher(in_data);
      if (!start || !busy) begin
        if (idle_left > 0) begin
          start <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (pending_cmds.size() > 0 &&
                     (!pending_cmds[0].drain || expected_matches.size() == 0)) begin
          in_data <= pending_cmds[0].item;
          start <= 1'b1;
          pending_cmds.pop_front();
          idle_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest expected match
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        if (out_data.pattern_id !== expected_matches[0].pattern_id) begin
          $display("%0t: pattern_id expected %0d actual %0d", $time,
                   expected_matches[0].pattern_id, out_data.pattern_id);
          errors++;
        end
        if (out_data.match_position !== expected_matches[0].match_position) begin
          $display("%0t: match_position expected %0d actual %0d", $time,
                   expected_matches[0].match_position, out_data.match_position);
          errors++;
        end
        if (out_data.last_match !== expected_matches[0].last_match) begin
          $display("%0t: last_match expected %0b actual %0b", $time,
                   expected_matches[0].last_match, out_data.last_match);
          errors++;
        end
        if (out_data.table_full !== expected_matches[0].table_full) begin
          $display("%0t: table_full expected %0b actual %0b", $time,
                   expected_matches[0].table_full, out_data.table_full);
          errors++;
        end
        void'(expected_matches.pop_front());
      end
    end
  end

  // run limit
  initial begin
    #60000000;
    $display("multi_pattern_matcher_core regression: fail");
    $finish;
  end

  // stimulus and end of run
  initial begin
    logic [7:0] alpha[3];
    int issued, npat, plen, ntext, guard;
    trie_clear();
    offset = '0;

    // directed: empty trie, unused opcode, ignored bits, duplicates, split pattern
    queue_cmd(mpm_pkg::OP_TEXT, 8'h00, 1'b1, 1'b1);
    queue_cmd(OP_UNUSED, 8'hff, 1'b1, 1'b1);
    queue_cmd(mpm_pkg::OP_PATTERN, 8'h00, 1'b0, 1'b1);
    queue_cmd(mpm_pkg::OP_PATTERN, 8'hff, 1'b1, 1'b0);
    queue_cmd(mpm_pkg::OP_PATTERN, 8'hff, 1'b1, 1'b1);
    queue_cmd(mpm_pkg::OP_PATTERN, 8'h00, 1'b0, 1'b0);
    queue_cmd(mpm_pkg::OP_PATTERN, 8'hff, 1'b1, 1'b0);
    queue_cmd(mpm_pkg::OP_TEXT, 8'h00, 1'b0, 1'b1);
    queue_cmd(mpm_pkg::OP_TEXT, 8'hff, 1'b1, 1'b0);
    queue_cmd(mpm_pkg::OP_TEXT, 8'hff, 1'b0, 1'b0);
    queue_cmd(mpm_pkg::OP_PATTERN, 8'h00, 1'b0, 1'b0);
    queue_cmd(mpm_pkg::OP_TEXT, 8'h00, 1'b0, 1'b0);
    queue_cmd(mpm_pkg::OP_PATTERN, 8'h00, 1'b1, 1'b0);
    queue_cmd(mpm_pkg::OP_TEXT, 8'h00, 1'b0, 1'b0);
    queue_cmd(mpm_pkg::OP_TEXT, 8'h00, 1'b0, 1'b0, 1'b1);
    queue_cmd(mpm_pkg::OP_CLEAR, 8'hff, 1'b1, 1'b1);
    queue_cmd(mpm_pkg::OP_TEXT, 8'h00, 1'b0, 1'b0);

    // pattern list full, the last pattern is not recorded
    queue_cmd(mpm_pkg::OP_CLEAR, 8'h00, 1'b0, 1'b0, 1'b1);
    for (int i = 0; i < 65; i++) queue_cmd(mpm_pkg::OP_PATTERN, i[7:0], 1'b1, 1'b0);
    queue_cmd(mpm_pkg::OP_TEXT, 8'h07, 1'b0, 1'b1);
    queue_cmd(mpm_pkg::OP_TEXT, 8'h07, 1'b0, 1'b0);
    queue_cmd(mpm_pkg::OP_TEXT, 8'h07, 1'b0, 1'b0);
    queue_cmd(mpm_pkg::OP_TEXT, 8'h40, 1'b0, 1'b0);

    // random phases: small alphabet, short patterns, text with some noise
    issued = 0;
    while (issued < 80) begin
      for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom_range(0, 255));
      queue_cmd(mpm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      npat = $urandom_range(2, 5);
      for (int p = 0; p < npat; p++) begin
        plen = $urandom_range(1, 3);
        for (int j = 0; j < plen; j++)
          queue_cmd(mpm_pkg::OP_PATTERN, alpha[$urandom_range(0, 2)], (j == plen - 1),
                    1'($urandom_range(0, 1)));
        issued += plen;
      end
      ntext = $urandom_range(10, 25);
      for (int t = 0; t < ntext; t++) begin
        case ($urandom_range(0, 19))
          0: queue_cmd(mpm_pkg::OP_TEXT, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'b0);
          1: queue_cmd(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
          2: queue_cmd(mpm_pkg::OP_PATTERN, alpha[$urandom_range(0, 2)],
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          default: queue_cmd(mpm_pkg::OP_TEXT, alpha[$urandom_range(0, 2)],
                             1'($urandom_range(0, 1)),
                             (t == 0) || ($urandom_range(0, 15) == 0));
        endcase
      end
      issued += ntext;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || start) @(posedge clk);
    while (expected_matches.size() > 0) @(posedge clk);
    guard = 0;
    while (busy && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_matches.size() == 0)
      $display("multi_pattern_matcher_core regression: pass");
    else
      $display("multi_pattern_matcher_core regression: fail");
    $finish;
  end

endmodule
